// ===== rtl/tbdpc_pkg.sv =====
// Shared types and constants for the two-button debounce and press classifier.
package tbdpc_pkg;

  localparam int unsigned TimeW = 32;
  localparam int unsigned MsW   = 16;
  localparam int unsigned EvW   = 2;
  localparam int unsigned IdxW  = 2;

  // Event codes
  localparam logic [EvW-1:0] EV_NONE        = 2'd0;
  localparam logic [EvW-1:0] EV_LEFT_SHORT  = 2'd1;
  localparam logic [EvW-1:0] EV_RIGHT_SHORT = 2'd2;
  localparam logic [EvW-1:0] EV_RIGHT_LONG  = 2'd3;

  // Configuration register indexes
  localparam logic [IdxW-1:0] REG_DEBOUNCE   = 2'd0;
  localparam logic [IdxW-1:0] REG_LONG_PRESS = 2'd1;
  localparam logic [IdxW-1:0] REG_LEFT_POL   = 2'd2;
  localparam logic [IdxW-1:0] REG_RIGHT_POL  = 2'd3;

  // Configuration reset values
  localparam logic [MsW-1:0] DEBOUNCE_RST   = 16'd20;
  localparam logic [MsW-1:0] LONG_PRESS_RST = 16'd1000;

  // Command codes
  localparam logic CMD_POLL = 1'b0;
  localparam logic CMD_TAKE = 1'b1;

  typedef struct packed {
    logic [MsW-1:0] debounce_ms;
    logic [MsW-1:0] long_press_ms;
    logic           left_low_true;
    logic           right_low_true;
  } cfg_t;

  typedef struct packed {
    logic short_ev;
    logic long_ev;
  } btn_ev_t;

endpackage

// ===== rtl/tbdpc_cfg.sv =====
// Configuration register file for the press classifier.
module tbdpc_cfg (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       wr_en,
  input  logic [tbdpc_pkg::IdxW-1:0] wr_index,
  input  logic [tbdpc_pkg::MsW-1:0]  wr_data,
  output tbdpc_pkg::cfg_t            cfg
);
  import tbdpc_pkg::*;

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce_ms    <= DEBOUNCE_RST;
      cfg_r.long_press_ms  <= LONG_PRESS_RST;
      cfg_r.left_low_true  <= 1'b1;
      cfg_r.right_low_true <= 1'b1;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_DEBOUNCE:   cfg_r.debounce_ms    <= wr_data;
        REG_LONG_PRESS: cfg_r.long_press_ms  <= wr_data;
        REG_LEFT_POL:   cfg_r.left_low_true  <= wr_data[0];
        REG_RIGHT_POL:  cfg_r.right_low_true <= wr_data[0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== rtl/tbdpc_button.sv =====
// Debounce and press timing for one button.
module tbdpc_button (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        step_en,
  input  logic [tbdpc_pkg::TimeW-1:0] now_ms,
  input  logic                        level,
  input  logic                        low_true,
  input  logic [tbdpc_pkg::MsW-1:0]   debounce_ms,
  input  logic [tbdpc_pkg::MsW-1:0]   long_press_ms,
  input  logic                        long_en,
  output tbdpc_pkg::btn_ev_t          ev
);
  import tbdpc_pkg::*;

  logic             prev_r, prev_nxt;
  logic             deb_r, deb_nxt;
  logic             lr_r, lr_nxt;
  logic [TimeW-1:0] chg_time_r, chg_time_nxt;
  logic [TimeW-1:0] press_time_r, press_time_nxt;

  logic             pressed;
  logic             restart;
  logic             stable;
  logic             accept;
  logic [TimeW-1:0] since_change;
  logic [TimeW-1:0] since_press;

  assign pressed        = level ^ low_true;
  // Restart the debounce timer on any raw change
  assign restart        = (pressed != prev_r);
  assign prev_nxt       = pressed;
  assign chg_time_nxt   = restart ? now_ms : chg_time_r;
  assign since_change   = now_ms - chg_time_nxt;
  assign stable         = since_change >= {{(TimeW-MsW){1'b0}}, debounce_ms};
  assign accept         = stable && (pressed != deb_r);
  assign press_time_nxt = (accept && pressed) ? now_ms : press_time_r;
  assign since_press    = now_ms - press_time_nxt;

  always_comb begin
    deb_nxt = deb_r;
    lr_nxt  = lr_r;
    ev      = '0;
    if (accept) begin
      deb_nxt = pressed;
      if (pressed) begin
        lr_nxt = 1'b0;
      end else if (!lr_r) begin
        ev.short_ev = 1'b1;
      end
    end
    if (stable && long_en && deb_nxt && !lr_nxt &&
        (since_press >= {{(TimeW-MsW){1'b0}}, long_press_ms})) begin
      lr_nxt     = 1'b1;
      ev.long_ev = 1'b1;
    end
    if (!step_en) begin
      ev = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r       <= 1'b0;
      deb_r        <= 1'b0;
      lr_r         <= 1'b0;
      chg_time_r   <= '0;
      press_time_r <= '0;
    end else if (step_en) begin
      prev_r       <= prev_nxt;
      deb_r        <= deb_nxt;
      lr_r         <= lr_nxt;
      chg_time_r   <= chg_time_nxt;
      press_time_r <= press_time_nxt;
    end
  end

endmodule

// ===== rtl/two_button_debounce_press_classifier_top.sv =====
// Top level of the two-button debounce and press classifier.
//
// Usage:
//   in_*  : one transfer per command. in_tuser is the command (0 poll, 1 take).
//           A poll samples both raw pin levels with a millisecond timestamp and
//           gives no result; a take returns the pending event and clears it.
//   out_* : one transfer per take, event code 0 none, 1 left short,
//           2 right short, 3 right long.
//   cfg_* : register writes, always ready; write only while the block is idle.
// Timing:
//   An input transfer lands in an input register; from there it is
//   processed against the button state and a take result is loaded into the
//   output register, which drives out_tvalid. One command is accepted every
//   cycle while no take is stuck behind a held result.
// Reset (rst_n low, synchronous): button state, pending event and both
//   pipeline valid bits clear; configuration returns to debounce 20 ms,
//   long press 1000 ms, both buttons active low.
// Stall: a held result blocks only a following take; polls keep flowing
//   past it. in_tready drops only when a take is stuck behind a held result.
module two_button_debounce_press_classifier_top (
  input  logic                       clk,
  input  logic                       rst_n,
  // Input channel
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [39:0]                in_tdata,  // [31:0] now_ms, [32] left_level,
                                                // [33] right_level, [39:34] zero
  input  logic                       in_tuser,  // [0] command
  // Result channel
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [7:0]                 out_tdata, // [1:0] event_code, [7:2] zero
  // Configuration write channel
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [tbdpc_pkg::IdxW-1:0] cfg_index,
  input  logic [tbdpc_pkg::MsW-1:0]  cfg_data
);
  import tbdpc_pkg::*;

  cfg_t cfg;

  // Input register
  logic             in_v_r;
  logic             cmd_r;
  logic [TimeW-1:0] now_r;
  logic             left_r;
  logic             right_r;

  // Result register and pending event
  logic             out_v_r;
  logic [EvW-1:0]   out_code_r;
  logic [EvW-1:0]   pend_r, pend_nxt;

  logic    advance;
  logic    poll_step;
  btn_ev_t left_ev;
  btn_ev_t right_ev;

  assign cfg_ready = 1'b1;

  tbdpc_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // A poll always advances; a take advances once the result register frees up
  assign advance   = in_v_r && ((cmd_r == CMD_POLL) || !out_v_r || out_tready);
  assign poll_step = advance && (cmd_r == CMD_POLL);
  assign in_tready = !in_v_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_tready) begin
      in_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      cmd_r   <= in_tuser;
      now_r   <= in_tdata[TimeW-1:0];
      left_r  <= in_tdata[TimeW];
      right_r <= in_tdata[TimeW+1];
    end
  end

  tbdpc_button u_left (
    .clk           (clk),
    .rst_n         (rst_n),
    .step_en       (poll_step),
    .now_ms        (now_r),
    .level         (left_r),
    .low_true      (cfg.left_low_true),
    .debounce_ms   (cfg.debounce_ms),
    .long_press_ms (cfg.long_press_ms),
    .long_en       (1'b0),
    .ev            (left_ev)
  );

  tbdpc_button u_right (
    .clk           (clk),
    .rst_n         (rst_n),
    .step_en       (poll_step),
    .now_ms        (now_r),
    .level         (right_r),
    .low_true      (cfg.right_low_true),
    .debounce_ms   (cfg.debounce_ms),
    .long_press_ms (cfg.long_press_ms),
    .long_en       (1'b1),
    .ev            (right_ev)
  );

  // Right is serviced after left, so its event overwrites
  always_comb begin
    pend_nxt = pend_r;
    priority if (right_ev.long_ev) begin
      pend_nxt = EV_RIGHT_LONG;
    end else if (right_ev.short_ev) begin
      pend_nxt = EV_RIGHT_SHORT;
    end else if (left_ev.short_ev) begin
      pend_nxt = EV_LEFT_SHORT;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= EV_NONE;
    end else if (advance && (cmd_r == CMD_TAKE)) begin
      pend_r <= EV_NONE;
    end else if (poll_step) begin
      pend_r <= pend_nxt;
    end
  end

  // Load the result on a take, drop it once transferred
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (advance && (cmd_r == CMD_TAKE)) begin
      out_v_r <= 1'b1;
    end else if (out_tready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && (cmd_r == CMD_TAKE)) begin
      out_code_r <= pend_r;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {{(8-EvW){1'b0}}, out_code_r};

endmodule

// ===== test/tb.sv =====
// Self-checking testbench for the two-button debounce and press classifier.
`timescale 1ns / 1ps

module tb;
  import tbdpc_pkg::*;

  localparam int CLK_HALF_NS  = 10;
  localparam int RESET_CYCLES = 4;
  // Polls give no result, so let the two-stage pipeline empty before a register write.
  localparam int SETTLE_CYCLES = 8;
  localparam int RUN_LIMIT_NS  = 20_000_000;
  localparam int SEGMENT_ITEMS = 100;

  typedef logic [EvW-1:0] ev_code_t;

  // An event code typed into the directed plan, or left to the predictor.
  typedef struct {
    bit       fixed;
    ev_code_t code;
  } typed_event_t;

  typedef enum logic {STEP_ITEM, STEP_WRITE} step_kind_t;

  typedef struct {
    step_kind_t       kind;
    logic             cmd;
    logic [TimeW-1:0] now;
    logic             lvl_l;
    logic             lvl_r;
    bit               fixed;
    ev_code_t         code;
    logic [IdxW-1:0]  idx;
    logic [MsW-1:0]   val;
  } plan_row_t;

  logic             clk;
  logic             rst_n      = 1'b0;
  logic             in_tvalid  = 1'b0;
  logic             in_tready;
  logic [39:0]      in_tdata   = '0;
  logic             in_tuser   = CMD_POLL;
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic [7:0]       out_tdata;
  logic             cfg_valid  = 1'b0;
  logic             cfg_ready;
  logic [IdxW-1:0]  cfg_index  = REG_DEBOUNCE;
  logic [MsW-1:0]   cfg_data   = '0;

  // Predictor state, index 0 left, 1 right
  logic             sample_prev [2];
  logic             held_state  [2];
  logic             long_done   [2];
  logic [TimeW-1:0] edge_ms     [2];
  logic [TimeW-1:0] down_ms     [2];
  ev_code_t         queued_event;
  logic [MsW-1:0]   cur_debounce;
  logic [MsW-1:0]   cur_long;
  logic             cur_left_low;
  logic             cur_right_low;

  ev_code_t     awaited_events[$];
  typed_event_t typed_events[$];
  plan_row_t    plan[$];

  int in_idle_pct  = 27;
  int out_idle_pct = 86;
  int errors       = 0;
  int items_sent   = 0;
  int events_seen  = 0;
  int settings_run = 0;

  two_button_debounce_press_classifier_top u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),   // [31:0] now_ms, [32] left_level, [33] right_level, [39:34] zero
    .in_tuser  (in_tuser),   // [0] command
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),  // [1:0] event_code, [7:2] zero
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_HALF_NS) clk = ~clk;
  end

  // End the run as failed if it hangs.
  initial begin
    #(RUN_LIMIT_NS);
    $display("simulation failed");
    $finish;
  end

  // Stall the result side at random.
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= out_idle_pct);
  end

  // Service one button the way the block does: restart the debounce timer on a
  // sampled change, accept a held level, latch short and (right only) long events.
  task automatic classify_button(input int b, input logic level, input logic act_low,
                                 input logic [TimeW-1:0] now);
    logic             pressed;
    logic [TimeW-1:0] held_for;
    logic [TimeW-1:0] down_for;
    pressed = act_low ? ~level : level;
    if (pressed != sample_prev[b]) begin
      sample_prev[b] = pressed;
      edge_ms[b]     = now;
    end
    held_for = now - edge_ms[b];
    if (held_for < {16'd0, cur_debounce}) return;
    if (pressed != held_state[b]) begin
      held_state[b] = pressed;
      if (pressed) begin
        down_ms[b]   = now;
        long_done[b] = 1'b0;
      end else if (!long_done[b]) begin
        queued_event = (b == 1) ? EV_RIGHT_SHORT : EV_LEFT_SHORT;
      end
    end
    down_for = now - down_ms[b];
    if (b == 1 && held_state[b] && !long_done[b] && down_for >= {16'd0, cur_long}) begin
      long_done[b] = 1'b1;
      queued_event = EV_RIGHT_LONG;
    end
  endtask

  // Track every transfer: check results first, then advance the predictor.
  always @(posedge clk) begin : watch
    ev_code_t     want;
    ev_code_t     model_code;
    typed_event_t typed;
    if (!rst_n) begin
      for (int b = 0; b < 2; b++) begin
        sample_prev[b] = 1'b0;
        held_state[b]  = 1'b0;
        long_done[b]   = 1'b0;
        edge_ms[b]     = '0;
        down_ms[b]     = '0;
      end
      queued_event  = EV_NONE;
      cur_debounce  = DEBOUNCE_RST;
      cur_long      = LONG_PRESS_RST;
      cur_left_low  = 1'b1;
      cur_right_low = 1'b1;
    end else begin
      if (out_tvalid && out_tready) begin
        if (awaited_events.size() == 0) begin
          $error("unexpected result transfer, event_code %0d", out_tdata[EvW-1:0]);
          errors++;
        end else begin
          want = awaited_events.pop_front();
          events_seen++;
          if (out_tdata[EvW-1:0] !== want) begin
            $error("event_code mismatch: expected %0d, actual %0d", want, out_tdata[EvW-1:0]);
            errors++;
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_DEBOUNCE:   cur_debounce  = cfg_data;
          REG_LONG_PRESS: cur_long      = cfg_data;
          REG_LEFT_POL:   cur_left_low  = cfg_data[0];
          REG_RIGHT_POL:  cur_right_low = cfg_data[0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        if (in_tuser == CMD_TAKE) begin
          // A take reads and clears the pending event; levels and time are ignored.
          model_code   = queued_event;
          queued_event = EV_NONE;
          typed        = typed_events.pop_front();
          awaited_events.push_back(typed.fixed ? typed.code : model_code);
        end else begin
          // Left goes first, so a right event overwrites a left one on the same poll.
          classify_button(0, in_tdata[32], cur_left_low, in_tdata[TimeW-1:0]);
          classify_button(1, in_tdata[33], cur_right_low, in_tdata[TimeW-1:0]);
        end
      end
    end
  end

  // Drive one command; hold it until the block takes the transfer.
  task automatic send_item(input logic cmd, input logic [TimeW-1:0] now, input logic lvl_l,
                           input logic lvl_r, input bit fixed, input ev_code_t code);
    cfg_valid <= 1'b0;
    if (cmd == CMD_TAKE) typed_events.push_back('{fixed, code});
    while ($urandom_range(99) < in_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {6'd0, lvl_r, lvl_l, now};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    items_sent++;
  endtask

  // Drop valid and wait until every awaited event has come out and the pipe is empty.
  task automatic settle();
    in_tvalid <= 1'b0;
    cfg_valid <= 1'b0;
    @(posedge clk);
    while (awaited_events.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [IdxW-1:0] idx, input logic [MsW-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  function automatic plan_row_t poll_row(input logic [TimeW-1:0] now, input logic lvl_l,
                                         input logic lvl_r);
    return '{STEP_ITEM, CMD_POLL, now, lvl_l, lvl_r, 1'b0, EV_NONE, REG_DEBOUNCE, '0};
  endfunction

  // Takes carry random time and levels, which the block must ignore.
  function automatic plan_row_t take_row(input bit fixed, input ev_code_t code);
    return '{STEP_ITEM, CMD_TAKE, $urandom(), 1'($urandom_range(1)), 1'($urandom_range(1)),
             fixed, code, REG_DEBOUNCE, '0};
  endfunction

  function automatic plan_row_t write_row(input logic [IdxW-1:0] idx, input logic [MsW-1:0] val);
    return '{STEP_WRITE, CMD_POLL, '0, 1'b0, 1'b0, 1'b0, EV_NONE, idx, val};
  endfunction

  // Random commands under one register setting: mostly a slowly advancing clock with
  // buttons that toggle now and then, so levels both bounce and settle; a few time
  // jumps and takes with random fields mixed in.
  task automatic run_segment(input logic [MsW-1:0] deb, input logic [MsW-1:0] hold,
                             input logic pol_l, input logic pol_r);
    logic [TimeW-1:0] tick;
    logic             lvl_l;
    logic             lvl_r;
    int               span;
    int               roll;
    int               n;
    settle();
    write_reg(REG_DEBOUNCE, deb);
    write_reg(REG_LONG_PRESS, hold);
    write_reg(REG_LEFT_POL, MsW'(pol_l));
    write_reg(REG_RIGHT_POL, MsW'(pol_r));
    settings_run++;
    tick  = $urandom();
    lvl_l = 1'($urandom_range(1));
    lvl_r = 1'($urandom_range(1));
    span  = (int'(deb) + int'(hold)) / 4 + 4;
    for (n = 0; n < SEGMENT_ITEMS; n++) begin
      roll = $urandom_range(99);
      if (roll < 18) begin
        send_item(CMD_TAKE, $urandom(), 1'($urandom_range(1)), 1'($urandom_range(1)),
                  1'b0, EV_NONE);
      end else begin
        if (roll < 21) tick = $urandom();
        else tick = tick + $urandom_range(span);
        if ($urandom_range(99) < 12) lvl_l = ~lvl_l;
        if ($urandom_range(99) < 12) lvl_r = ~lvl_r;
        send_item(CMD_POLL, tick, lvl_l, lvl_r, 1'b0, EV_NONE);
      end
    end
  endtask

  initial begin : stimulus
    plan_row_t row;
    int        k;
    bit        last_write;

    // Directed plan under reset settings (20 ms debounce, 1000 ms long, active low).
    plan.push_back(take_row(1'b1, EV_NONE));             // nothing pending after reset
    plan.push_back(poll_row(32'd0, 1'b1, 1'b1));
    plan.push_back(poll_row(32'd5, 1'b0, 1'b1));         // left goes down
    plan.push_back(poll_row(32'd25, 1'b0, 1'b1));        // left press accepted
    plan.push_back(poll_row(32'd30, 1'b1, 1'b0));        // left up, right down
    plan.push_back(poll_row(32'd50, 1'b1, 1'b0));        // left short latched
    plan.push_back(take_row(1'b1, EV_LEFT_SHORT));
    plan.push_back(take_row(1'b1, EV_NONE));             // take clears the event
    plan.push_back(poll_row(32'd1050, 1'b1, 1'b0));      // right held exactly long enough
    plan.push_back(poll_row(32'd1060, 1'b1, 1'b1));
    plan.push_back(poll_row(32'd1080, 1'b1, 1'b1));      // release after long: no short
    plan.push_back(take_row(1'b1, EV_RIGHT_LONG));
    plan.push_back(poll_row(32'hFFFF_FFFF, 1'b1, 1'b0)); // debounce across the time wrap
    plan.push_back(poll_row(32'h0000_0013, 1'b1, 1'b0));
    plan.push_back(poll_row(32'h0000_0020, 1'b1, 1'b1));
    plan.push_back(poll_row(32'h0000_0034, 1'b1, 1'b1));
    plan.push_back(take_row(1'b0, EV_NONE));
    // Zero debounce and zero long press, both buttons active high.
    plan.push_back(write_row(REG_DEBOUNCE, 16'd0));
    plan.push_back(write_row(REG_LONG_PRESS, 16'd0));
    plan.push_back(write_row(REG_LEFT_POL, 16'd0));
    plan.push_back(write_row(REG_RIGHT_POL, 16'd0));
    plan.push_back(poll_row(32'd100, 1'b1, 1'b1));       // right long on the press itself
    plan.push_back(poll_row(32'd101, 1'b0, 1'b0));       // left short overwrites it
    plan.push_back(take_row(1'b0, EV_NONE));
    // Longest debounce and hold, back to active low.
    plan.push_back(write_row(REG_DEBOUNCE, 16'hFFFF));
    plan.push_back(write_row(REG_LONG_PRESS, 16'hFFFF));
    plan.push_back(write_row(REG_LEFT_POL, 16'd1));
    plan.push_back(write_row(REG_RIGHT_POL, 16'd1));
    plan.push_back(poll_row(32'h0000_1000, 1'b0, 1'b0));
    plan.push_back(poll_row(32'h0001_0FFE, 1'b0, 1'b0)); // one short of the debounce time
    plan.push_back(poll_row(32'h0001_0FFF, 1'b0, 1'b0));
    plan.push_back(take_row(1'b0, EV_NONE));

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // Phase one: sender idles lightly, receiver stalls heavily.
    in_idle_pct  = 27;
    out_idle_pct = 86;
    settings_run = 3;
    last_write   = 1'b0;
    for (k = 0; k < plan.size(); k++) begin
      row = plan[k];
      if (row.kind == STEP_WRITE) begin
        if (!last_write) settle();
        write_reg(row.idx, row.val);
      end else begin
        send_item(row.cmd, row.now, row.lvl_l, row.lvl_r, row.fixed, row.code);
      end
      last_write = (row.kind == STEP_WRITE);
    end

    run_segment(16'd20, 16'd1000, 1'b1, 1'b1);
    run_segment(16'd0, 16'd0, 1'b0, 1'b0);
    run_segment(16'hFFFF, 16'hFFFF, 1'b1, 1'b0);

    // Phase two: the other way round.
    in_idle_pct  = 86;
    out_idle_pct = 27;
    run_segment(16'd3, 16'd40, 1'b0, 1'b1);
    run_segment(MsW'($urandom_range(30)), MsW'($urandom_range(300)),
                1'($urandom_range(1)), 1'($urandom_range(1)));
    run_segment(16'd0, 16'hFFFF, 1'b1, 1'b1);

    // Phase three: no idling on either side.
    in_idle_pct  = 0;
    out_idle_pct = 0;
    run_segment(16'hFFFF, 16'd0, 1'b0, 1'b0);
    run_segment(MsW'($urandom_range(30)), MsW'($urandom_range(300)),
                1'($urandom_range(1)), 1'($urandom_range(1)));

    settle();
    $display("Sent %0d commands under %0d register settings; checked %0d event results.",
             items_sent, settings_run, events_seen);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/tbdpc_pkg.sv
rtl/tbdpc_cfg.sv
rtl/tbdpc_button.sv
rtl/two_button_debounce_press_classifier_top.sv
test/tb.sv
